### rtl/t3l_pkg.sv
// ----------------------------------------------------------------------------
// t3l_pkg: shared types and constants of the 3D torus life block
// Controller state, ring operation codes, register indexes and the
// neighborhood count used by the cell update rule.
// ----------------------------------------------------------------------------
package t3l_pkg;

	localparam int PLANE_W     = 64;
	localparam int INDEX_W     = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int GEN_W       = 8;
	localparam int RULE_W      = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_GENERATIONS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_LOW    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_HIGH   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_LOW   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_HIGH  = 3'd4;

	localparam logic [GEN_W-1:0]  GENERATIONS_RST = 8'd10;
	localparam logic [RULE_W-1:0] KEEP_LOW_RST    = 5'd6;
	localparam logic [RULE_W-1:0] KEEP_HIGH_RST   = 5'd8;
	localparam logic [RULE_W-1:0] BIRTH_LOW_RST   = 5'd9;
	localparam logic [RULE_W-1:0] BIRTH_HIGH_RST  = 5'd10;

	typedef enum logic [1:0] {
		S_LOAD,
		S_RUN,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_STEP,
		OP_ROTATE
	} ring_op_t;

	typedef struct packed {
		ring_op_t op;
		logic     first;
		logic     last;
	} ring_ctrl_t;

	// Counts the live bits of a 3x3x3 neighborhood given as nine triples.
	function automatic logic [RULE_W-1:0] count_nbhd(input logic [26:0] v);
		logic [1:0]        t [9];
		logic [RULE_W-1:0] s;
		for (int k = 0; k < 9; k++) begin
			t[k] = 2'(v[3*k]) + 2'(v[3*k+1]) + 2'(v[3*k+2]);
		end
		s = '0;
		for (int k = 0; k < 9; k++) begin
			s = s + RULE_W'(t[k]);
		end
		return s;
	endfunction

endpackage

### rtl/t3l_plane_cell.sv
// ----------------------------------------------------------------------------
// t3l_plane_cell: one x-plane storage cell of the ring
// Holds one plane and takes the plane of its neighbor when the ring shifts.
// ----------------------------------------------------------------------------
module t3l_plane_cell #(
	parameter int CELLS = 64
) (
	input  logic             clk,
	input  logic             shift_en,
	input  logic [CELLS-1:0] d,
	output logic [CELLS-1:0] q
);

	logic [CELLS-1:0] plane_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			plane_q <= d;
		end
	end

	assign q = plane_q;

endmodule

### rtl/t3l_rule.sv
// ----------------------------------------------------------------------------
// t3l_rule: next-generation update of one x-plane
// Counts the 26 wrapped neighbors of every cell of a plane from the previous,
// current and following planes and applies the keep and birth ranges.
// ----------------------------------------------------------------------------
module t3l_rule #(
	parameter int Y_SIZE = 8,
	parameter int Z_SIZE = 8
) (
	input  logic [Y_SIZE*Z_SIZE-1:0]     prev_plane,
	input  logic [Y_SIZE*Z_SIZE-1:0]     cur_plane,
	input  logic [Y_SIZE*Z_SIZE-1:0]     next_plane,
	input  logic [t3l_pkg::RULE_W-1:0]   keep_low,
	input  logic [t3l_pkg::RULE_W-1:0]   keep_high,
	input  logic [t3l_pkg::RULE_W-1:0]   birth_low,
	input  logic [t3l_pkg::RULE_W-1:0]   birth_high,
	output logic [Y_SIZE*Z_SIZE-1:0]     new_plane
);

	for (genvar gy = 0; gy < Y_SIZE; gy++) begin : g_row
		for (genvar gz = 0; gz < Z_SIZE; gz++) begin : g_cell
			localparam int YM = (gy + Y_SIZE - 1) % Y_SIZE;
			localparam int YP = (gy + 1) % Y_SIZE;
			localparam int ZM = (gz + Z_SIZE - 1) % Z_SIZE;
			localparam int ZP = (gz + 1) % Z_SIZE;
			localparam int RM = YM * Z_SIZE;
			localparam int R0 = gy * Z_SIZE;
			localparam int RP = YP * Z_SIZE;

			logic [26:0]                nb;
			logic [t3l_pkg::RULE_W-1:0] n;
			logic                       keep;
			logic                       birth;

			// The center cell itself stands as a zero in the middle triple.
			assign nb = {
				prev_plane[RM+ZM], prev_plane[RM+gz], prev_plane[RM+ZP],
				prev_plane[R0+ZM], prev_plane[R0+gz], prev_plane[R0+ZP],
				prev_plane[RP+ZM], prev_plane[RP+gz], prev_plane[RP+ZP],
				cur_plane[RM+ZM],  cur_plane[RM+gz],  cur_plane[RM+ZP],
				cur_plane[R0+ZM],  1'b0,              cur_plane[R0+ZP],
				cur_plane[RP+ZM],  cur_plane[RP+gz],  cur_plane[RP+ZP],
				next_plane[RM+ZM], next_plane[RM+gz], next_plane[RM+ZP],
				next_plane[R0+ZM], next_plane[R0+gz], next_plane[R0+ZP],
				next_plane[RP+ZM], next_plane[RP+gz], next_plane[RP+ZP]
			};

			assign n     = t3l_pkg::count_nbhd(nb);
			assign keep  = (n >= keep_low) && (n <= keep_high);
			assign birth = (n >= birth_low) && (n <= birth_high);

			assign new_plane[R0+gz] = keep ? cur_plane[R0+gz] : birth;
		end
	end

endmodule

### rtl/t3l_ctrl.sv
// ----------------------------------------------------------------------------
// t3l_ctrl: sequencer of the plane ring
// Counts loaded planes, steps the ring through the configured generations
// and then rotates it once more to emit every plane.
// ----------------------------------------------------------------------------
module t3l_ctrl #(
	parameter int X_SIZE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [t3l_pkg::GEN_W-1:0]      generations,
	output logic                           busy,
	output t3l_pkg::ring_ctrl_t            ring_ctrl,
	output logic                           result_valid,
	output logic [t3l_pkg::INDEX_W-1:0]    plane_index,
	output logic                           last_plane
);

	localparam int CW = $clog2(X_SIZE);
	localparam logic [CW-1:0] LAST_POS = CW'(X_SIZE - 1);

	t3l_pkg::state_t           state_q;
	t3l_pkg::state_t           state_d;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             cnt_d;
	logic [t3l_pkg::GEN_W-1:0] gen_q;
	logic [t3l_pkg::GEN_W-1:0] gen_d;
	logic                      at_last;

	assign at_last = (cnt_q == LAST_POS);

	// Next state and counters.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		gen_d   = gen_q;
		unique case (state_q)
			t3l_pkg::S_LOAD: begin
				if (start) begin
					if (at_last) begin
						cnt_d   = '0;
						gen_d   = '0;
						state_d = (generations == '0) ? t3l_pkg::S_EMIT : t3l_pkg::S_RUN;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			t3l_pkg::S_RUN: begin
				if (at_last) begin
					cnt_d = '0;
					gen_d = gen_q + 1'b1;
					if (gen_d == generations) begin
						state_d = t3l_pkg::S_EMIT;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			t3l_pkg::S_EMIT: begin
				if (at_last) begin
					cnt_d   = '0;
					state_d = t3l_pkg::S_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = t3l_pkg::S_LOAD;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		busy            = 1'b1;
		ring_ctrl.op    = t3l_pkg::OP_HOLD;
		ring_ctrl.first = 1'b0;
		ring_ctrl.last  = 1'b0;
		result_valid    = 1'b0;
		unique case (state_q)
			t3l_pkg::S_LOAD: begin
				busy         = 1'b0;
				ring_ctrl.op = start ? t3l_pkg::OP_LOAD : t3l_pkg::OP_HOLD;
			end
			t3l_pkg::S_RUN: begin
				ring_ctrl.op    = t3l_pkg::OP_STEP;
				ring_ctrl.first = (cnt_q == '0);
				ring_ctrl.last  = at_last;
			end
			t3l_pkg::S_EMIT: begin
				ring_ctrl.op = t3l_pkg::OP_ROTATE;
				result_valid = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign plane_index = t3l_pkg::INDEX_W'(cnt_q);
	assign last_plane  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= t3l_pkg::S_LOAD;
			cnt_q   <= '0;
			gen_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			gen_q   <= gen_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_POS)
		else $error("plane counter out of range");

	a_first_last: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_ctrl.first && ring_ctrl.last))
		else $error("first and last plane flagged together");

	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_valid && last_plane))
		else $error("block went idle without emitting the last plane");

	a_run_ends_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == t3l_pkg::S_RUN && at_last && gen_d == generations)
		|=> (state_q == t3l_pkg::S_EMIT && cnt_q == '0))
		else $error("emission did not follow the final generation");
`endif

endmodule

### rtl/torus_3d_life_generation_unit.sv
// ----------------------------------------------------------------------------
// torus_3d_life_generation_unit: 3D Game of Life on a torus
// Loads a grid one x-plane per item into a ring of plane cells, steps the
// ring through the configured generations and emits every plane.
// ----------------------------------------------------------------------------
// After the last plane of a grid is accepted, the ring is stepped through the
// configured generations, then X_SIZE results follow, one per cycle. One
// plane is taken per cycle while start is high and the block is idle. A grid's
// run time is set by the single plane update unit that the ring passes once
// per generation. Results cannot be stalled.
// Reset clears the sequencer and loads the default rule registers.
module torus_3d_life_generation_unit #(
	parameter int X_SIZE = 8,
	parameter int Y_SIZE = 8,
	parameter int Z_SIZE = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [t3l_pkg::PLANE_W-1:0]        plane_cells,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [t3l_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [t3l_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               result_valid,
	output logic [t3l_pkg::PLANE_W-1:0]        result_plane,
	output logic [t3l_pkg::INDEX_W-1:0]        plane_index,
	output logic                               last_plane
);

	localparam int CELLS = Y_SIZE * Z_SIZE;

	logic [t3l_pkg::GEN_W-1:0]  generations_q;
	logic [t3l_pkg::RULE_W-1:0] keep_low_q;
	logic [t3l_pkg::RULE_W-1:0] keep_high_q;
	logic [t3l_pkg::RULE_W-1:0] birth_low_q;
	logic [t3l_pkg::RULE_W-1:0] birth_high_q;

	t3l_pkg::ring_ctrl_t        ring_ctrl;
	logic [CELLS-1:0]           ring_q [X_SIZE];
	logic [CELLS-1:0]           tail_d;
	logic [CELLS-1:0]           prev_plane;
	logic [CELLS-1:0]           next_plane;
	logic [CELLS-1:0]           new_plane;
	logic [CELLS-1:0]           prev_q;
	logic [CELLS-1:0]           first_q;
	logic                       shift_en;

	// Configuration registers; writes are never held off.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generations_q <= t3l_pkg::GENERATIONS_RST;
			keep_low_q    <= t3l_pkg::KEEP_LOW_RST;
			keep_high_q   <= t3l_pkg::KEEP_HIGH_RST;
			birth_low_q   <= t3l_pkg::BIRTH_LOW_RST;
			birth_high_q  <= t3l_pkg::BIRTH_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				t3l_pkg::REG_GENERATIONS: generations_q <= cfg_data;
				t3l_pkg::REG_KEEP_LOW:    keep_low_q    <= t3l_pkg::RULE_W'(cfg_data);
				t3l_pkg::REG_KEEP_HIGH:   keep_high_q   <= t3l_pkg::RULE_W'(cfg_data);
				t3l_pkg::REG_BIRTH_LOW:   birth_low_q   <= t3l_pkg::RULE_W'(cfg_data);
				t3l_pkg::REG_BIRTH_HIGH:  birth_high_q  <= t3l_pkg::RULE_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	t3l_ctrl #(
		.X_SIZE(X_SIZE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.generations  (generations_q),
		.busy         (busy),
		.ring_ctrl    (ring_ctrl),
		.result_valid (result_valid),
		.plane_index  (plane_index),
		.last_plane   (last_plane)
	);

	assign shift_en = (ring_ctrl.op != t3l_pkg::OP_HOLD);

	// The head of the ring holds the plane being updated. The old copies of the
	// plane just updated and of plane zero stand in for neighbors that the
	// ring has already overwritten.
	assign prev_plane = ring_ctrl.first ? ring_q[X_SIZE-1] : prev_q;
	assign next_plane = ring_ctrl.last ? first_q : ring_q[1];

	t3l_rule #(
		.Y_SIZE(Y_SIZE),
		.Z_SIZE(Z_SIZE)
	) u_rule (
		.prev_plane (prev_plane),
		.cur_plane  (ring_q[0]),
		.next_plane (next_plane),
		.keep_low   (keep_low_q),
		.keep_high  (keep_high_q),
		.birth_low  (birth_low_q),
		.birth_high (birth_high_q),
		.new_plane  (new_plane)
	);

	always_comb begin
		unique case (ring_ctrl.op)
			t3l_pkg::OP_LOAD: tail_d = plane_cells[CELLS-1:0];
			t3l_pkg::OP_STEP: tail_d = new_plane;
			default:          tail_d = ring_q[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_ctrl.op == t3l_pkg::OP_STEP) begin
			prev_q <= ring_q[0];
			if (ring_ctrl.first) begin
				first_q <= ring_q[0];
			end
		end
	end

	for (genvar gi = 0; gi < X_SIZE; gi++) begin : g_ring
		logic [CELLS-1:0] cell_d;
		if (gi == X_SIZE - 1) begin : g_tail
			assign cell_d = tail_d;
		end else begin : g_body
			assign cell_d = ring_q[gi+1];
		end
		t3l_plane_cell #(
			.CELLS(CELLS)
		) u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (ring_q[gi])
		);
	end

	assign result_plane = t3l_pkg::PLANE_W'(ring_q[0]);

endmodule
